FILE: design/square_channel_envelope_length_macros.svh
// assertion macros shared by the square channel rtl
`ifndef SQUARE_CHANNEL_ENVELOPE_LENGTH_MACROS_SVH
`define SQUARE_CHANNEL_ENVELOPE_LENGTH_MACROS_SVH

// same-cycle implication, checked while out of reset
`define SQCH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked while out of reset
`define SQCH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/sqch_pkg.sv
// shared types, codes and tables of the square channel
`default_nettype none

package sqch_pkg;

    typedef enum logic [1:0] {
        OP_TRIGGER  = 2'd0,
        OP_LENGTH   = 2'd1,
        OP_ENVELOPE = 2'd2,
        OP_SAMPLE   = 2'd3
    } t_op;

    localparam logic [2:0] CFG_DUTY_PATTERN    = 3'd0;
    localparam logic [2:0] CFG_START_VOLUME    = 3'd1;
    localparam logic [2:0] CFG_ENVELOPE_UP     = 3'd2;
    localparam logic [2:0] CFG_ENVELOPE_PERIOD = 3'd3;
    localparam logic [2:0] CFG_LENGTH_GATE     = 3'd4;
    localparam logic [2:0] CFG_FREQUENCY       = 3'd5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [6:0]  LEN_FULL      = 7'd64;
    localparam logic [6:0]  LEN_FULL_M1   = 7'd63;
    localparam logic [3:0]  VOL_MAX       = 4'd15;
    localparam logic [11:0] FREQ_BASE     = 12'd2048;
    localparam logic [3:0]  ENV_PERIOD_0  = 4'd8;

    typedef struct packed {
        logic [1:0]  duty_pattern;
        logic [3:0]  start_volume;
        logic        envelope_up;
        logic [2:0]  envelope_period;
        logic        length_gate;
        logic [10:0] frequency;
    } t_cfg;

    typedef struct packed {
        logic        enabled_flag;
        logic [6:0]  length_count;
        logic [3:0]  volume_level;
        logic [3:0]  envelope_countdown;
        logic        envelope_stopped;
        logic [13:0] freq_countdown;
    } t_state;

    typedef struct packed {
        t_op        op;
        logic       next_not_length_step;
        logic       next_is_envelope_step;
        logic [2:0] duty_position;
    } t_item;

    typedef struct packed {
        logic [3:0]  sample_value;
        logic        channel_on;
        logic [3:0]  volume_now;
        logic [6:0]  length_left;
        logic [13:0] period_timer;
    } t_result;

    // waveform of each duty setting, bit n is duty position n
    function automatic logic [7:0] duty_wave(input logic [1:0] pattern);
        logic [7:0] wave;
        case (pattern)
            2'd0:    wave = 8'b1000_0000;
            2'd1:    wave = 8'b1000_0001;
            2'd2:    wave = 8'b1110_0001;
            default: wave = 8'b0111_1110;
        endcase
        return wave;
    endfunction

    // envelope period of zero behaves as eight
    function automatic logic [3:0] env_reload(input logic [2:0] period);
        return (period == 3'd0) ? ENV_PERIOD_0 : {1'b0, period};
    endfunction

endpackage

`default_nettype wire

FILE: design/sqch_cfg.sv
// configuration register file of the square channel
`default_nettype none

module sqch_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [sqch_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [sqch_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output sqch_pkg::t_cfg                     o_cfg
);
    import sqch_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DUTY_PATTERN:    n_cfg.duty_pattern    = i_cfg_data[1:0];
                CFG_START_VOLUME:    n_cfg.start_volume    = i_cfg_data[3:0];
                CFG_ENVELOPE_UP:     n_cfg.envelope_up     = i_cfg_data[0];
                CFG_ENVELOPE_PERIOD: n_cfg.envelope_period = i_cfg_data[2:0];
                CFG_LENGTH_GATE:     n_cfg.length_gate     = i_cfg_data[0];
                CFG_FREQUENCY:       n_cfg.frequency       = i_cfg_data[10:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: design/sqch_step.sv
// next channel state and result beat for one operation
`default_nettype none

module sqch_step (
    input  wire sqch_pkg::t_cfg    i_cfg,
    input  wire sqch_pkg::t_state  i_state,
    input  wire sqch_pkg::t_item   i_item,
    output sqch_pkg::t_state  o_state,
    output sqch_pkg::t_result o_result
);
    import sqch_pkg::*;

    logic [11:0] w_freq_span;
    logic [6:0]  w_len_dec;
    logic [7:0]  w_wave;
    logic [3:0]  w_sample;

    assign w_freq_span = FREQ_BASE - {1'b0, i_cfg.frequency};
    assign w_len_dec   = i_state.length_count - 7'd1;
    assign w_wave      = duty_wave(i_cfg.duty_pattern);

    always_comb begin
        o_state  = i_state;
        w_sample = '0;
        case (i_item.op)
            OP_TRIGGER: begin
                o_state.enabled_flag = 1'b1;
                if (i_state.length_count == '0) begin
                    o_state.length_count =
                        (i_cfg.length_gate && i_item.next_not_length_step) ?
                        LEN_FULL_M1 : LEN_FULL;
                end
                o_state.envelope_stopped   = 1'b0;
                o_state.envelope_countdown = env_reload(i_cfg.envelope_period)
                                           + {3'd0, i_item.next_is_envelope_step};
                o_state.volume_level       = i_cfg.start_volume;
                // reload is span times four, low two timer bits survive
                o_state.freq_countdown = {w_freq_span, i_state.freq_countdown[1:0]};
                if (i_cfg.start_volume == '0 && !i_cfg.envelope_up) begin
                    o_state.enabled_flag = 1'b0;
                end
            end
            OP_LENGTH: begin
                if (i_cfg.length_gate && i_state.length_count != '0) begin
                    o_state.length_count = w_len_dec;
                    if (w_len_dec == '0) begin
                        o_state.enabled_flag = 1'b0;
                    end
                end
            end
            OP_ENVELOPE: begin
                if (!i_state.envelope_stopped) begin
                    if (i_state.envelope_countdown <= 4'd1) begin
                        o_state.envelope_countdown = env_reload(i_cfg.envelope_period);
                        if (i_cfg.envelope_period != '0) begin
                            if (i_cfg.envelope_up) begin
                                if (i_state.volume_level < VOL_MAX) begin
                                    o_state.volume_level = i_state.volume_level + 4'd1;
                                end else begin
                                    o_state.envelope_stopped = 1'b1;
                                end
                            end else begin
                                if (i_state.volume_level > 4'd0) begin
                                    o_state.volume_level = i_state.volume_level - 4'd1;
                                end else begin
                                    o_state.envelope_stopped = 1'b1;
                                end
                            end
                        end
                    end else begin
                        o_state.envelope_countdown = i_state.envelope_countdown - 4'd1;
                    end
                end
            end
            OP_SAMPLE: begin
                w_sample = w_wave[i_item.duty_position] ? i_state.volume_level : 4'd0;
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

    assign o_result.sample_value = w_sample;
    assign o_result.channel_on   = o_state.enabled_flag;
    assign o_result.volume_now   = o_state.volume_level;
    assign o_result.length_left  = o_state.length_count;
    assign o_result.period_timer = o_state.freq_countdown;

endmodule

`default_nettype wire

FILE: design/square_channel_envelope_length.sv
// square wave channel: envelope, length counter and timer reload per operation
//
// Input channel (i_in_valid / o_in_ready) carries one operation per beat:
// trigger, length clock, envelope clock or sample. Output channel
// (o_out_valid / i_out_ready) returns exactly one result beat per input beat,
// in order, holding the sample value and the channel state after the step.
// Path: an accepted beat is held in the input register, then moves on to the
// result register (two register stages: input register, then result register).
// Throughput: one beat per cycle while the receiver does not stall; the channel
// state is updated as a beat moves from the input to the result register.
// When the receiver stalls, the result register holds and the input register
// still takes one more beat; o_in_ready drops only when both are full.
// Configuration: write i_cfg_data to register i_cfg_idx while i_cfg_we is
// high; writes are meant only while no beat is in flight. Unknown indexes
// are ignored.
// Reset (synchronous, i_rst_n low): both stages empty, channel state and all
// configuration registers cleared to zero.
`default_nettype none

module square_channel_envelope_length (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [sqch_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [sqch_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [1:0]                        i_operation,
    input  wire logic                              i_next_not_length_step,
    input  wire logic                              i_next_is_envelope_step,
    input  wire logic [2:0]                        i_duty_position,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [3:0]                             o_sample_value,
    output logic                                   o_channel_on,
    output logic [3:0]                             o_volume_now,
    output logic [6:0]                             o_length_left,
    output logic [13:0]                            o_period_timer
);
    import sqch_pkg::*;

    `include "square_channel_envelope_length_macros.svh"

    t_cfg    w_cfg;
    t_item   r_in;
    logic    r_in_vld;
    t_result r_out;
    logic    r_out_vld;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    logic    w_adv;
    logic    w_take;

    sqch_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    sqch_step u_step (
        .i_cfg    (w_cfg),
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // beat moves from input register to result register
    assign w_adv      = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_adv;
    assign w_take     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '0;
        end else begin
            if (w_take) begin
                r_in_vld <= 1'b1;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in.op                    <= t_op'(i_operation);
            r_in.next_not_length_step  <= i_next_not_length_step;
            r_in.next_is_envelope_step <= i_next_is_envelope_step;
            r_in.duty_position         <= i_duty_position;
        end
        if (w_adv) begin
            r_out <= n_result;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_sample_value = r_out.sample_value;
    assign o_channel_on   = r_out.channel_on;
    assign o_volume_now   = r_out.volume_now;
    assign o_length_left  = r_out.length_left;
    assign o_period_timer = r_out.period_timer;

    `SQCH_ASSERT_NOW(a_stall_holds, r_out_vld && !i_out_ready, !w_adv,
        "result overwritten while stalled")
    `SQCH_ASSERT_NOW(a_full_not_ready, r_in_vld && !w_adv, !o_in_ready,
        "ready high with both stages full")
    `SQCH_ASSERT_NEXT(a_dac_off,
        w_adv && r_in.op == OP_TRIGGER && w_cfg.start_volume == 4'd0 && !w_cfg.envelope_up,
        !r_state.enabled_flag, "trigger with dac off left channel on")
    `SQCH_ASSERT_NEXT(a_len_expire,
        w_adv && r_in.op == OP_LENGTH && w_cfg.length_gate && r_state.length_count == 7'd1,
        !r_state.enabled_flag && r_state.length_count == 7'd0,
        "length expiry did not stop channel")

endmodule

`default_nettype wire

FILE: bench/square_channel_envelope_length_tb.sv
// self-checking bench for the square channel: predicts every result beat and checks it under random flow control
`timescale 1ns / 100ps

module square_channel_envelope_length_tb;
    import sqch_pkg::*;

    // channel model and queue of results still owed by the block
    class square_channel_scoreboard;
        t_cfg        regs       = '0;
        logic        chan_on    = 1'b0;
        logic [6:0]  len_count  = '0;
        logic [3:0]  volume     = '0;
        logic [3:0]  env_count  = '0;
        logic        env_halted = 1'b0;
        logic [13:0] timer      = '0;
        t_result     expected_results[$];
        int          mismatches = 0;
        int          results_seen = 0;

        task report(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DUTY_PATTERN:    regs.duty_pattern    = data[1:0];
                CFG_START_VOLUME:    regs.start_volume    = data[3:0];
                CFG_ENVELOPE_UP:     regs.envelope_up     = data[0];
                CFG_ENVELOPE_PERIOD: regs.envelope_period = data[2:0];
                CFG_LENGTH_GATE:     regs.length_gate     = data[0];
                CFG_FREQUENCY:       regs.frequency       = data[10:0];
                default: ;
            endcase
        endfunction

        // advance the channel by one operation and queue the result it owes
        function void note_item(t_item it);
            t_result    r;
            logic [3:0] steps;
            logic [7:0] wave;
            int         span;
            r = '0;
            steps = (regs.envelope_period == 3'd0) ? 4'd8 : 4'(regs.envelope_period);
            case (it.op)
                OP_TRIGGER: begin
                    chan_on = 1'b1;
                    if (len_count == 0)
                        len_count = (regs.length_gate && it.next_not_length_step) ? 7'd63 : 7'd64;
                    env_halted = 1'b0;
                    env_count = steps + 4'(it.next_is_envelope_step);
                    volume = regs.start_volume;
                    // timer keeps its two low bits across a trigger
                    span = (2048 - int'(regs.frequency)) * 4;
                    timer = {span[13:2], timer[1:0]};
                    if (regs.start_volume == 0 && !regs.envelope_up)
                        chan_on = 1'b0;
                end
                OP_LENGTH: begin
                    if (regs.length_gate && len_count != 0) begin
                        len_count = len_count - 7'd1;
                        if (len_count == 0)
                            chan_on = 1'b0;
                    end
                end
                OP_ENVELOPE: begin
                    if (!env_halted) begin
                        if (env_count <= 4'd1) begin
                            env_count = steps;
                            if (regs.envelope_period != 3'd0) begin
                                if (regs.envelope_up) begin
                                    if (volume < 4'd15) volume = volume + 4'd1;
                                    else env_halted = 1'b1;
                                end else begin
                                    if (volume > 4'd0) volume = volume - 4'd1;
                                    else env_halted = 1'b1;
                                end
                            end
                        end else begin
                            env_count = env_count - 4'd1;
                        end
                    end
                end
                default: begin
                    case (regs.duty_pattern)
                        2'd0:    wave = 8'h80;
                        2'd1:    wave = 8'h81;
                        2'd2:    wave = 8'hE1;
                        default: wave = 8'h7E;
                    endcase
                    r.sample_value = wave[it.duty_position] ? volume : 4'd0;
                end
            endcase
            r.channel_on   = chan_on;
            r.volume_now   = volume;
            r.length_left  = len_count;
            r.period_timer = timer;
            expected_results.push_back(r);
        endfunction

        task check_result(t_result got);
            t_result want;
            results_seen++;
            if (expected_results.size() == 0) begin
                report($sformatf("result beat %0d arrived with nothing expected", results_seen));
                return;
            end
            want = expected_results.pop_front();
            if (got.sample_value !== want.sample_value)
                report($sformatf("beat %0d sample_value: got %0d, expected %0d",
                                 results_seen, got.sample_value, want.sample_value));
            if (got.channel_on !== want.channel_on)
                report($sformatf("beat %0d channel_on: got %0d, expected %0d",
                                 results_seen, got.channel_on, want.channel_on));
            if (got.volume_now !== want.volume_now)
                report($sformatf("beat %0d volume_now: got %0d, expected %0d",
                                 results_seen, got.volume_now, want.volume_now));
            if (got.length_left !== want.length_left)
                report($sformatf("beat %0d length_left: got %0d, expected %0d",
                                 results_seen, got.length_left, want.length_left));
            if (got.period_timer !== want.period_timer)
                report($sformatf("beat %0d period_timer: got %0d, expected %0d",
                                 results_seen, got.period_timer, want.period_timer));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [1:0]            i_operation = '0;
    logic                  i_next_not_length_step = 1'b0;
    logic                  i_next_is_envelope_step = 1'b0;
    logic [2:0]            i_duty_position = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [3:0]            o_sample_value;
    logic                  o_channel_on;
    logic [3:0]            o_volume_now;
    logic [6:0]            o_length_left;
    logic [13:0]           o_period_timer;

    int send_idle_pct = 0;
    int stall_pct = 0;

    square_channel_scoreboard sb = new();

    square_channel_envelope_length dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_idx              (i_cfg_idx),
        .i_cfg_data             (i_cfg_data),
        .i_in_valid             (i_in_valid),
        .o_in_ready             (o_in_ready),
        .i_operation            (i_operation),
        .i_next_not_length_step (i_next_not_length_step),
        .i_next_is_envelope_step(i_next_is_envelope_step),
        .i_duty_position        (i_duty_position),
        .o_out_valid            (o_out_valid),
        .i_out_ready            (i_out_ready),
        .o_sample_value         (o_sample_value),
        .o_channel_on           (o_channel_on),
        .o_volume_now           (o_volume_now),
        .o_length_left          (o_length_left),
        .o_period_timer         (o_period_timer)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // watch register writes and both channels at every edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                sb.write_reg(i_cfg_idx, i_cfg_data);
            if (o_out_valid && i_out_ready)
                sb.check_result(t_result'{o_sample_value, o_channel_on, o_volume_now,
                                          o_length_left, o_period_timer});
            if (i_in_valid && o_in_ready)
                sb.note_item(t_item'{t_op'(i_operation), i_next_not_length_step,
                                     i_next_is_envelope_step, i_duty_position});
        end
    end

    task automatic set_idling(int mode);
        case (mode)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 68; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 68; end
            default: begin send_idle_pct = 12; stall_pct = 12; end
        endcase
    endtask

    task automatic load_settings(t_cfg c);
        logic [CFG_IDX_W-1:0]  idxs[6];
        logic [CFG_DATA_W-1:0] vals[6];
        idxs = '{CFG_DUTY_PATTERN, CFG_START_VOLUME, CFG_ENVELOPE_UP,
                 CFG_ENVELOPE_PERIOD, CFG_LENGTH_GATE, CFG_FREQUENCY};
        vals = '{11'(c.duty_pattern), 11'(c.start_volume), 11'(c.envelope_up),
                 11'(c.envelope_period), 11'(c.length_gate), c.frequency};
        for (int i = 0; i < 6; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idxs[i];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_item(t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid              <= 1'b1;
        i_operation             <= it.op;
        i_next_not_length_step  <= it.next_not_length_step;
        i_next_is_envelope_step <= it.next_is_envelope_step;
        i_duty_position         <= it.duty_position;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_op(t_op op, logic nl, logic ne, logic [2:0] pos);
        send_item(t_item'{op, nl, ne, pos});
    endtask

    // hold the sender until every owed result beat has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_random(int trig_pct, int len_pct, int env_pct);
        t_item it;
        int    r;
        r = $urandom_range(99);
        if (r < trig_pct)                          it.op = OP_TRIGGER;
        else if (r < trig_pct + len_pct)           it.op = OP_LENGTH;
        else if (r < trig_pct + len_pct + env_pct) it.op = OP_ENVELOPE;
        else                                       it.op = OP_SAMPLE;
        it.next_not_length_step  = 1'($urandom_range(1));
        it.next_is_envelope_step = 1'($urandom_range(1));
        it.duty_position         = 3'($urandom_range(7));
        send_item(it);
    endtask

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        t_cfg c;
        int   trig_pct;
        int   len_pct;
        int   env_pct;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_idling(0);

        // loudest setting, envelope rising into its ceiling, length loads 63
        load_settings(t_cfg'{2'd3, 4'd15, 1'b1, 3'd1, 1'b1, 11'd2047});
        send_op(OP_TRIGGER, 1'b1, 1'b1, 3'd0);
        send_op(OP_SAMPLE, 1'b0, 1'b0, 3'd0);
        send_op(OP_SAMPLE, 1'b0, 1'b0, 3'd7);
        send_op(OP_SAMPLE, 1'b1, 1'b1, 3'd1);
        send_op(OP_ENVELOPE, 1'b0, 1'b0, 3'd0);
        send_op(OP_ENVELOPE, 1'b0, 1'b0, 3'd0);
        send_op(OP_ENVELOPE, 1'b0, 1'b0, 3'd0);
        send_op(OP_LENGTH, 1'b0, 1'b0, 3'd0);
        send_op(OP_LENGTH, 1'b1, 1'b1, 3'd7);
        send_op(OP_TRIGGER, 1'b0, 1'b0, 3'd0);
        drain();

        // dac off kills the trigger, envelope period zero holds the volume
        load_settings('0);
        send_op(OP_TRIGGER, 1'b1, 1'b1, 3'd0);
        send_op(OP_LENGTH, 1'b0, 1'b0, 3'd0);
        send_op(OP_ENVELOPE, 1'b0, 1'b0, 3'd0);
        send_op(OP_ENVELOPE, 1'b0, 1'b1, 3'd0);
        send_op(OP_SAMPLE, 1'b0, 1'b0, 3'd7);
        send_op(OP_SAMPLE, 1'b0, 1'b0, 3'd0);
        drain();

        // envelope falling below zero stops
        load_settings(t_cfg'{2'd2, 4'd1, 1'b0, 3'd1, 1'b1, 11'd1024});
        send_op(OP_TRIGGER, 1'b1, 1'b0, 3'd0);
        send_op(OP_ENVELOPE, 1'b0, 1'b0, 3'd0);
        send_op(OP_ENVELOPE, 1'b0, 1'b0, 3'd0);
        send_op(OP_ENVELOPE, 1'b0, 1'b0, 3'd0);
        send_op(OP_SAMPLE, 1'b0, 1'b0, 3'd5);
        drain();

        for (int phase = 0; phase < 14; phase++) begin
            if (phase == 0) begin
                c = '0;
            end else if (phase == 1) begin
                c = '1;
            end else begin
                c.duty_pattern    = 2'($urandom_range(3));
                c.start_volume    = 4'($urandom_range(15));
                c.envelope_up     = 1'($urandom_range(1));
                c.envelope_period = 3'($urandom_range(7));
                c.length_gate     = ($urandom_range(3) != 0);
                c.frequency       = 11'($urandom_range(2047));
            end
            load_settings(c);
            set_idling(phase % 4);
            // rare triggers let the length counter run out, frequent ones churn state
            case (phase % 3)
                0: begin trig_pct = 1;  len_pct = 60; env_pct = 20; end
                1: begin trig_pct = 10; len_pct = 25; env_pct = 30; end
                default: begin trig_pct = 25; len_pct = 25; env_pct = 25; end
            endcase
            for (int n = 0; n < 125; n++) begin
                if (phase == 6 && n == 60)
                    drain();
                send_random(trig_pct, len_pct, env_pct);
            end
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (sb.expected_results.size() != 0)
            sb.report($sformatf("%0d result beats never arrived", sb.expected_results.size()));
        if (sb.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
